FILE: design/a64dp_pkg.sv
package a64dp_pkg;

  localparam int XLEN      = 64;
  localparam int WORD      = 32;
  localparam int REG_COUNT = 31;
  localparam int REG_AW    = 5;

  // register number that reads as zero and drops writes
  localparam logic [REG_AW-1:0] ZERO_REG = 5'd31;

  localparam logic KIND_EXEC = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // arithmetic group
  localparam logic [1:0] OPC_ADD  = 2'd0;
  localparam logic [1:0] OPC_ADDS = 2'd1;
  localparam logic [1:0] OPC_SUB  = 2'd2;
  localparam logic [1:0] OPC_SUBS = 2'd3;
  // logical group
  localparam logic [1:0] OPC_AND  = 2'd0;
  localparam logic [1:0] OPC_ORR  = 2'd1;
  localparam logic [1:0] OPC_EOR  = 2'd2;
  localparam logic [1:0] OPC_ANDS = 2'd3;

  // multiply-accumulate encoding
  localparam logic [1:0] MUL_OPC = 2'd0;
  localparam logic [3:0] MUL_OPR = 4'b1000;

  typedef enum logic [1:0] {
    SHIFT_LSL,
    SHIFT_LSR,
    SHIFT_ASR,
    SHIFT_ROR
  } shift_t;

  typedef struct packed {
    logic              kind;
    logic              sf;
    logic [1:0]        opc;
    logic              m;
    logic [REG_AW-1:0] rm;
    logic [3:0]        opr;
    logic [5:0]        operand;
    logic [REG_AW-1:0] rn;
    logic [REG_AW-1:0] rd;
    logic [XLEN-1:0]   load_value;
  } item_t;

  typedef struct packed {
    logic [XLEN-1:0] value;
    logic [3:0]      nzcv;
    logic            sets_flags;
  } alu_res_t;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

  typedef struct packed {
    logic [XLEN-1:0] ra;
    logic            sub;
    logic            sf;
  } mac_ctl_t;

  function automatic logic [XLEN-1:0] size_mask(input logic sf);
    return sf ? {XLEN{1'b1}} : {{(XLEN-WORD){1'b0}}, {WORD{1'b1}}};
  endfunction

endpackage

FILE: design/a64dp_in_if.sv
interface a64dp_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        sf;
  logic [1:0]  opc;
  logic        m;
  logic [4:0]  rm;
  logic [3:0]  opr;
  logic [5:0]  operand;
  logic [4:0]  rn;
  logic [4:0]  rd;
  logic [63:0] load_value;

  modport source (
    output valid, kind, sf, opc, m, rm, opr, operand, rn, rd, load_value,
    input  ready
  );
  modport sink (
    input  valid, kind, sf, opc, m, rm, opr, operand, rn, rd, load_value,
    output ready
  );
endinterface

FILE: design/a64dp_out_if.sv
interface a64dp_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [63:0] result_value;
  logic        write_done;
  logic [3:0]  flags;

  modport source (
    output valid, status, result_value, write_done, flags,
    input  ready
  );
  modport sink (
    input  valid, status, result_value, write_done, flags,
    output ready
  );
endinterface

FILE: design/a64dp_regfile.sv
module a64dp_regfile (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [a64dp_pkg::REG_AW-1:0]   raddr_a,
  input  logic [a64dp_pkg::REG_AW-1:0]   raddr_b,
  input  logic [a64dp_pkg::REG_AW-1:0]   raddr_c,
  input  a64dp_pkg::rf_wr_t              wr,
  output logic [a64dp_pkg::XLEN-1:0]     rdata_a,
  output logic [a64dp_pkg::XLEN-1:0]     rdata_b,
  output logic [a64dp_pkg::XLEN-1:0]     rdata_c
);

  // two copies written together: one serves rn/rm, the other the accumulate port
  logic [a64dp_pkg::XLEN-1:0] mem_ab [a64dp_pkg::REG_COUNT];
  logic [a64dp_pkg::XLEN-1:0] mem_c  [a64dp_pkg::REG_COUNT];
  logic [a64dp_pkg::REG_COUNT-1:0] valid_r;

  logic [a64dp_pkg::XLEN-1:0] data_a_r, data_b_r, data_c_r;
  logic                       vld_a_r, vld_b_r, vld_c_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_ab[wr.addr] <= wr.data;
      mem_c[wr.addr]  <= wr.data;
    end
    data_a_r <= mem_ab[raddr_a];
    data_b_r <= mem_ab[raddr_b];
    data_c_r <= mem_c[raddr_c];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      vld_a_r <= (raddr_a != a64dp_pkg::ZERO_REG) && valid_r[raddr_a];
      vld_b_r <= (raddr_b != a64dp_pkg::ZERO_REG) && valid_r[raddr_b];
      vld_c_r <= (raddr_c != a64dp_pkg::ZERO_REG) && valid_r[raddr_c];
    end
  end

  assign rdata_a = vld_a_r ? data_a_r : '0;
  assign rdata_b = vld_b_r ? data_b_r : '0;
  assign rdata_c = vld_c_r ? data_c_r : '0;

endmodule

FILE: design/a64dp_alu.sv
module a64dp_alu (
  input  logic                       sf,
  input  logic [1:0]                 opc,
  input  logic [3:0]                 opr,
  input  logic [5:0]                 amount,
  input  logic [a64dp_pkg::XLEN-1:0] a,
  input  logic [a64dp_pkg::XLEN-1:0] b,
  output a64dp_pkg::alu_res_t        res
);

  localparam int XLEN = a64dp_pkg::XLEN;
  localparam int WORD = a64dp_pkg::WORD;

  logic [XLEN-1:0]   mask;
  logic [XLEN-1:0]   am;
  logic [XLEN-1:0]   v;
  logic [XLEN-1:0]   vs;
  logic [2*XLEN-1:0] rot;
  logic [2*XLEN-1:0] rot_sh;
  logic [XLEN-1:0]   sh_raw;
  logic [XLEN-1:0]   sh;
  logic [XLEN-1:0]   bb;
  logic [XLEN-1:0]   addend;
  logic [XLEN:0]     sum;
  logic [XLEN-1:0]   sum_v;
  logic [XLEN-1:0]   logic_v;
  logic [XLEN-1:0]   ovf_vec;
  logic              sub;
  logic              carry;

  function automatic logic msb(input logic [XLEN-1:0] x, input logic wide);
    return wide ? x[XLEN-1] : x[WORD-1];
  endfunction

  always_comb begin
    mask   = a64dp_pkg::size_mask(sf);
    am     = a & mask;
    v      = b & mask;
    vs     = sf ? v : {{(XLEN-WORD){v[WORD-1]}}, v[WORD-1:0]};
    rot    = sf ? {v, v} : {{XLEN{1'b0}}, v[WORD-1:0], v[WORD-1:0]};
    rot_sh = rot >> amount;

    unique case (a64dp_pkg::shift_t'(opr[2:1]))
      a64dp_pkg::SHIFT_LSL: sh_raw = v << amount;
      a64dp_pkg::SHIFT_LSR: sh_raw = v >> amount;
      a64dp_pkg::SHIFT_ASR: sh_raw = $signed(vs) >>> amount;
      a64dp_pkg::SHIFT_ROR: sh_raw = rot_sh[XLEN-1:0];
      default:              sh_raw = v;
    endcase
    sh = sh_raw & mask;
    bb = opr[0] ? (~sh & mask) : sh;

    // SUB and SUBS run as a + ~b + 1
    sub     = (opc == a64dp_pkg::OPC_SUB) || (opc == a64dp_pkg::OPC_SUBS);
    addend  = sub ? (~bb & mask) : bb;
    sum     = {1'b0, am} + {1'b0, addend} + {{XLEN{1'b0}}, sub};
    sum_v   = sum[XLEN-1:0] & mask;
    carry   = sf ? sum[XLEN] : sum[WORD];
    ovf_vec = ~(am ^ addend) & (am ^ sum_v);

    unique case (opc)
      a64dp_pkg::OPC_AND:  logic_v = am & bb;
      a64dp_pkg::OPC_ORR:  logic_v = am | bb;
      a64dp_pkg::OPC_EOR:  logic_v = am ^ bb;
      a64dp_pkg::OPC_ANDS: logic_v = am & bb;
      default:             logic_v = am & bb;
    endcase

    if (opr[3]) begin
      res.value      = sum_v;
      res.nzcv       = {msb(sum_v, sf), sum_v == '0, carry, msb(ovf_vec, sf)};
      res.sets_flags = (opc == a64dp_pkg::OPC_ADDS) || (opc == a64dp_pkg::OPC_SUBS);
    end else begin
      res.value      = logic_v;
      res.nzcv       = {msb(logic_v, sf), logic_v == '0, 2'b00};
      res.sets_flags = (opc == a64dp_pkg::OPC_ANDS);
    end
  end

endmodule

FILE: design/a64dp_mac.sv
module a64dp_mac (
  input  logic                       clk,
  input  logic                       en,
  input  logic [a64dp_pkg::XLEN-1:0] a,
  input  logic [a64dp_pkg::XLEN-1:0] b,
  input  a64dp_pkg::mac_ctl_t        ctl,
  output logic [a64dp_pkg::XLEN-1:0] value
);

  localparam int XLEN = a64dp_pkg::XLEN;
  localparam int WORD = a64dp_pkg::WORD;

  logic [XLEN-1:0] lolo_nxt, lolo_r;
  logic [WORD-1:0] lohi_nxt, lohi_r;
  logic [WORD-1:0] hilo_nxt, hilo_r;
  logic [WORD-1:0] cross_sum;
  logic [XLEN-1:0] prod;
  logic [XLEN-1:0] acc;

  // low 64 bits of the product from three 32x32 partial products
  always_comb begin
    lolo_nxt = XLEN'(a[WORD-1:0]) * XLEN'(b[WORD-1:0]);
    lohi_nxt = a[WORD-1:0] * b[XLEN-1:WORD];
    hilo_nxt = a[XLEN-1:WORD] * b[WORD-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lolo_r <= lolo_nxt;
      lohi_r <= lohi_nxt;
      hilo_r <= hilo_nxt;
    end
  end

  always_comb begin
    cross_sum = lohi_r + hilo_r;
    prod      = lolo_r + {cross_sum, {WORD{1'b0}}};
    acc       = ctl.sub ? (ctl.ra - prod) : (ctl.ra + prod);
    value     = acc & a64dp_pkg::size_mask(ctl.sf);
  end

endmodule

FILE: design/arm64_register_data_processing.sv
// AArch64 register-form data-processing unit. Each input item either executes
// one shifted-register ADD/ADDS/SUB/SUBS/AND/ORR/EOR/ANDS (optionally with an
// inverted second operand in the logical group) or MADD/MSUB against a
// 31-entry register file, or loads a register with a 64-bit value; every item
// yields exactly one result item carrying status, the computed value,
// whether a register was written, and NZCV after the item. Register 31 reads
// as zero and drops writes; 32-bit mode works on the low word and
// zero-extends. Rejected encodings write nothing and leave the flags. The
// pipeline is three registers deep (operand read, execute, result), and one
// item is taken per cycle while the output is not stalled and no multiply
// hazard holds an item. Results of ALU and load items forward straight to the
// next item; an item that reads the destination of the multiply-accumulate
// just ahead of it waits until that multiply leaves the second stage, since
// the multiply finishes its 64-bit sum only in the second stage. The register
// file is two copies of a 31-entry memory with registered reads plus per-entry
// valid bits, so reset takes effect at once with no clearing pass.
module arm64_register_data_processing (
  input logic             clk,
  input logic             rst_n,
  a64dp_in_if.sink        in_ch,
  a64dp_out_if.source     out_ch
);

  localparam int XLEN   = a64dp_pkg::XLEN;
  localparam int REG_AW = a64dp_pkg::REG_AW;

  typedef struct packed {
    logic              ok;
    logic              is_mul;
    logic              wen;
    logic [REG_AW-1:0] rd;
    logic [XLEN-1:0]   value;
    logic [3:0]        nzcv;
    logic              sets_flags;
  } s2_t;

  a64dp_pkg::item_t    in_item;
  a64dp_pkg::item_t    rd_src;
  a64dp_pkg::item_t    s1_r;
  logic                s1_v_r;

  s2_t                 s2_r, s2_nxt;
  logic                s2_v_r;
  a64dp_pkg::mac_ctl_t mac_r, mac_nxt;

  logic                out_v_r;
  logic                out_status_r;
  logic [XLEN-1:0]     out_value_r;
  logic                out_wd_r;
  logic [3:0]          out_flags_r;

  logic [3:0]          flags_r;
  a64dp_pkg::rf_wr_t   wr;
  a64dp_pkg::rf_wr_t   wb_r;

  logic [XLEN-1:0]     rdata_a, rdata_b, rdata_c;
  logic [XLEN-1:0]     op_rn, op_rm, op_ra;
  logic [XLEN-1:0]     mul_val;
  logic [XLEN-1:0]     fin_val;
  logic [3:0]          fin_flags;
  a64dp_pkg::alu_res_t alu_res;

  logic out_free, s2_adv, s1_adv, in_rdy, in_acc, hazard, s2_fwd;
  logic s1_arith, s1_ok, s1_exec;

  // newest value of a source register: youngest older item first
  function automatic logic [XLEN-1:0] fwd(
    input logic [REG_AW-1:0] addr,
    input logic [XLEN-1:0]   mem_data,
    input logic              s2_en,
    input logic [REG_AW-1:0] s2_rd,
    input logic [XLEN-1:0]   s2_val,
    input a64dp_pkg::rf_wr_t wb
  );
    logic [XLEN-1:0] v;
    priority if (addr == a64dp_pkg::ZERO_REG) begin
      v = '0;
    end else if (s2_en && (s2_rd == addr)) begin
      v = s2_val;
    end else if (wb.en && (wb.addr == addr)) begin
      v = wb.data;
    end else begin
      v = mem_data;
    end
    return v;
  endfunction

  always_comb begin
    in_item.kind       = in_ch.kind;
    in_item.sf         = in_ch.sf;
    in_item.opc        = in_ch.opc;
    in_item.m          = in_ch.m;
    in_item.rm         = in_ch.rm;
    in_item.opr        = in_ch.opr;
    in_item.operand    = in_ch.operand;
    in_item.rn         = in_ch.rn;
    in_item.rd         = in_ch.rd;
    in_item.load_value = in_ch.load_value;
  end

  // Handshake: each stage advances when the one after it is empty or moving.
  assign out_free = !out_v_r || out_ch.ready;
  assign s2_adv   = s2_v_r && out_free;
  assign s1_exec  = (s1_r.kind == a64dp_pkg::KIND_EXEC);

  // Hold an item that reads the destination of a multiply still in execute.
  assign hazard = s2_v_r && s2_r.is_mul && s2_r.wen && s1_exec &&
                  ((s1_r.rn == s2_r.rd) || (s1_r.rm == s2_r.rd) ||
                   (s1_r.m && (s1_r.operand[REG_AW-1:0] == s2_r.rd)));

  assign s1_adv      = s1_v_r && (!s2_v_r || out_free) && !hazard;
  assign in_rdy      = !s1_v_r || s1_adv;
  assign in_acc      = in_ch.valid && in_rdy;
  assign in_ch.ready = in_rdy;

  // Read for whichever item sits in stage one next cycle; a held item re-reads
  // so that its data never misses more than the latest write.
  assign rd_src = in_rdy ? in_item : s1_r;

  a64dp_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .raddr_a (rd_src.rn),
    .raddr_b (rd_src.rm),
    .raddr_c (rd_src.operand[REG_AW-1:0]),
    .wr      (wr),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b),
    .rdata_c (rdata_c)
  );

  // Stage one: pick operands, decode, run the ALU and the partial products.
  assign s2_fwd = s2_v_r && !s2_r.is_mul && s2_r.wen;

  always_comb begin
    op_rn = fwd(s1_r.rn, rdata_a, s2_fwd, s2_r.rd, s2_r.value, wb_r);
    op_rm = fwd(s1_r.rm, rdata_b, s2_fwd, s2_r.rd, s2_r.value, wb_r);
    op_ra = fwd(s1_r.operand[REG_AW-1:0], rdata_c, s2_fwd, s2_r.rd, s2_r.value, wb_r);
  end

  a64dp_alu u_alu (
    .sf     (s1_r.sf),
    .opc    (s1_r.opc),
    .opr    (s1_r.opr),
    .amount (s1_r.operand),
    .a      (op_rn),
    .b      (op_rm),
    .res    (alu_res)
  );

  assign s1_arith = s1_r.opr[3];

  always_comb begin
    // reject: multiply with a stray opc/opr, an over-long 32-bit shift, or an
    // arithmetic op asking for inversion or rotate
    priority if (!s1_exec) begin
      s1_ok = 1'b1;
    end else if (s1_r.m) begin
      s1_ok = (s1_r.opc == a64dp_pkg::MUL_OPC) && (s1_r.opr == a64dp_pkg::MUL_OPR);
    end else begin
      s1_ok = !(!s1_r.sf && s1_r.operand[5]) &&
              !(s1_arith && (s1_r.opr[0] ||
                (a64dp_pkg::shift_t'(s1_r.opr[2:1]) == a64dp_pkg::SHIFT_ROR)));
    end

    s2_nxt.ok         = s1_ok;
    s2_nxt.is_mul     = s1_exec && s1_r.m && s1_ok;
    s2_nxt.wen        = s1_ok && (s1_r.rd != a64dp_pkg::ZERO_REG);
    s2_nxt.rd         = s1_r.rd;
    s2_nxt.nzcv       = alu_res.nzcv;
    s2_nxt.sets_flags = s1_exec && !s1_r.m && s1_ok && alu_res.sets_flags;
    if (!s1_exec) begin
      s2_nxt.value = s1_r.load_value;
    end else if (s1_ok && !s1_r.m) begin
      s2_nxt.value = alu_res.value;
    end else begin
      s2_nxt.value = '0;
    end

    mac_nxt.ra  = op_ra;
    mac_nxt.sub = s1_r.operand[5];
    mac_nxt.sf  = s1_r.sf;
  end

  // Stage two: finish the multiply-accumulate, write back, settle flags.
  a64dp_mac u_mac (
    .clk   (clk),
    .en    (s1_adv),
    .a     (op_rn),
    .b     (op_rm),
    .ctl   (mac_r),
    .value (mul_val)
  );

  always_comb begin
    fin_val   = s2_r.is_mul ? mul_val : s2_r.value;
    fin_flags = s2_r.sets_flags ? s2_r.nzcv : flags_r;
    wr.en     = s2_adv && s2_r.wen;
    wr.addr   = s2_r.rd;
    wr.data   = fin_val;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      flags_r <= '0;
      wb_r    <= '0;
    end else begin
      if (in_rdy) begin
        s1_v_r <= in_ch.valid;
      end
      if (s1_adv) begin
        s2_v_r <= 1'b1;
      end else if (s2_adv) begin
        s2_v_r <= 1'b0;
      end
      if (s2_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if (s2_adv && s2_r.sets_flags) begin
        flags_r <= s2_r.nzcv;
      end
      // remember the write of this edge for the item reading next cycle
      wb_r <= wr;
    end
  end

  // Payload registers: advance with their stage, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= in_item;
    end
    if (s1_adv) begin
      s2_r  <= s2_nxt;
      mac_r <= mac_nxt;
    end
    if (s2_adv) begin
      out_status_r <= s2_r.ok ? a64dp_pkg::STATUS_OK : a64dp_pkg::STATUS_BAD;
      out_value_r  <= fin_val;
      out_wd_r     <= s2_r.wen;
      out_flags_r  <= fin_flags;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.write_done   = out_wd_r;
  assign out_ch.flags        = out_flags_r;

endmodule
